FILE: hdl/rgb2nv12_pkg.sv
package rgb2nv12_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int FW_W     = 13;
   localparam int FH_W     = 13;
   localparam int STRIDE_W = 14;
   localparam int OFS_W    = 26;
   localparam int PIX_W    = 8;
   localparam int ACC_W    = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 14;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_STRIDE   = 2'd2;

   localparam logic [FW_W-1:0]     FRAME_WIDTH_RST  = 13'd640;
   localparam logic [FH_W-1:0]     FRAME_HEIGHT_RST = 13'd480;
   localparam logic [STRIDE_W-1:0] OUT_STRIDE_RST   = 14'd640;

   localparam int Y_R    = 66;
   localparam int Y_G    = 129;
   localparam int Y_B    = 25;
   localparam int Y_OFS  = 16;
   localparam int CB_R   = 38;
   localparam int CB_G   = 74;
   localparam int CB_B   = 112;
   localparam int CR_R   = 112;
   localparam int CR_G   = 94;
   localparam int CR_B   = 18;
   localparam int ROUND  = 128;
   localparam int C_BIAS = 32768;
   localparam int FRAC_BITS = 8;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic             luma_valid;
      logic [OFS_W-1:0] luma_offset;
      logic             chroma_valid;
      logic [PIX_W-1:0] cb;
      logic [PIX_W-1:0] cr;
      logic [OFS_W-1:0] chroma_offset;
      logic             frame_end;
   } result_type;

endpackage

FILE: hdl/rgb2nv12_req_if.sv
interface rgb2nv12_req_if import rgb2nv12_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/rgb2nv12_rsp_if.sv
interface rgb2nv12_rsp_if import rgb2nv12_pkg::*; ();
   logic       valid;
   logic       ready;
   result_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/rgb_to_nv12_converter.sv
// Channel    Dir  Handshake    Payload
// req_chan   in   valid/ready  blue, green, red (one pixel, raster order)
// rsp_chan   out  valid/ready  luma, offsets, cb/cr, valid flags, frame_end
// csr        in   write only   csr_write_en, csr_index, csr_wdata
//
// One pixel per cycle sustained while rsp is not stalled; a req transaction passes
// through the stage-one register and then the result register before rsp valid rises.
// Stage one registers the pixel and its column/row; stage two holds the
// colour products and the stride multiplies in the result register.
// Synchronous reset clears the counters and valids and sets the CSRs to defaults.
// A stalled rsp holds the result; req stays ready while stage one can drain.
module rgb_to_nv12_converter import rgb2nv12_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   rgb2nv12_req_if.sink           req_chan,
   rgb2nv12_rsp_if.source         rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int PROD_W = ROW_W + 2 + STRIDE_W;
   localparam logic [COL_W:0] W_MIN = (COL_W+1)'(2);
   localparam logic [COL_W:0] W_MAX = (COL_W+1)'(MAX_WIDTH - (MAX_WIDTH % 2));
   localparam logic [ROW_W:0] H_MIN = (ROW_W+1)'(2);
   localparam logic [ROW_W:0] H_MAX = (ROW_W+1)'(MAX_HEIGHT);

   logic [FW_W-1:0]     frame_width_ff, frame_width_in;
   logic [FH_W-1:0]     frame_height_ff, frame_height_in;
   logic [STRIDE_W-1:0] out_stride_ff, out_stride_in;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             s1_valid_ff, s1_valid_in;
   pixel_type        s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_yv_ff, s1_cv_ff, s1_fe_ff;

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;

   logic [FW_W-1:0] fw_even;
   logic [COL_W:0]  eff_w, col_inc;
   logic [ROW_W:0]  eff_h, h_even, row_inc;
   logic            last_col, last_row, yv, cv;
   logic            req_fire, s1_adv;

   logic [ACC_W-1:0]  y_sum, cb_sum, cr_sum;
   logic [PROD_W-1:0] luma_prod, chroma_prod, chroma_row;

   // configuration
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      out_stride_in   = out_stride_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[FH_W-1:0];
            CSR_OUT_STRIDE:   out_stride_in   = csr_wdata[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      fw_even = {frame_width_ff[FW_W-1:1], 1'b0};
      if (fw_even < FW_W'(2)) begin
         eff_w = W_MIN;
      end else if (32'(fw_even) > 32'(MAX_WIDTH)) begin
         eff_w = W_MAX;
      end else begin
         eff_w = (COL_W+1)'(fw_even);
      end
      if (frame_height_ff < FH_W'(2)) begin
         eff_h = H_MIN;
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = H_MAX;
      end else begin
         eff_h = (ROW_W+1)'(frame_height_ff);
      end
      h_even = {eff_h[ROW_W:1], 1'b0};
   end

   // position tracking and stage one
   assign s1_adv         = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      col_inc  = {1'b0, col_ff} + (COL_W+1)'(1);
      row_inc  = {1'b0, row_ff} + (ROW_W+1)'(1);
      last_col = col_inc >= eff_w;
      last_row = row_inc >= eff_h;
      yv       = {1'b0, row_ff} < h_even;
      cv       = yv && !row_ff[0] && !col_ff[0];
      col_in   = col_ff;
      row_in   = row_ff;
      if (req_fire) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
      s1_valid_in = req_fire || (s1_valid_ff && !s1_adv);
   end

   // stage two: colour maths and offsets
   always_comb begin
      y_sum = ACC_W'(s1_pix_ff.red) * ACC_W'(Y_R) + ACC_W'(s1_pix_ff.green) * ACC_W'(Y_G)
            + ACC_W'(s1_pix_ff.blue) * ACC_W'(Y_B) + ACC_W'(ROUND);
      cb_sum = ACC_W'(s1_pix_ff.blue) * ACC_W'(CB_B) + ACC_W'(ROUND + C_BIAS)
             - ACC_W'(s1_pix_ff.red) * ACC_W'(CB_R) - ACC_W'(s1_pix_ff.green) * ACC_W'(CB_G);
      cr_sum = ACC_W'(s1_pix_ff.red) * ACC_W'(CR_R) + ACC_W'(ROUND + C_BIAS)
             - ACC_W'(s1_pix_ff.green) * ACC_W'(CR_G) - ACC_W'(s1_pix_ff.blue) * ACC_W'(CR_B);
      chroma_row  = PROD_W'(s1_row_ff >> 1) + PROD_W'(eff_h);
      luma_prod   = PROD_W'(s1_row_ff) * PROD_W'(out_stride_ff);
      chroma_prod = chroma_row * PROD_W'(out_stride_ff);

      out_data_in               = '0;
      out_data_in.luma_valid    = s1_yv_ff;
      out_data_in.chroma_valid  = s1_cv_ff;
      out_data_in.frame_end     = s1_fe_ff;
      if (s1_yv_ff) begin
         out_data_in.luma        = y_sum[ACC_W-1:FRAC_BITS] + PIX_W'(Y_OFS);
         out_data_in.luma_offset = OFS_W'(luma_prod) + OFS_W'(s1_col_ff);
      end
      if (s1_cv_ff) begin
         out_data_in.cb            = cb_sum[ACC_W-1:FRAC_BITS];
         out_data_in.cr            = cr_sum[ACC_W-1:FRAC_BITS];
         out_data_in.chroma_offset = OFS_W'(chroma_prod) + OFS_W'(s1_col_ff);
      end
      out_valid_in = (s1_valid_ff && s1_adv) || (out_valid_ff && !rsp_chan.ready);
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         out_stride_ff   <= OUT_STRIDE_RST;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         out_stride_ff   <= out_stride_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff <= req_chan.data;
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
         s1_yv_ff  <= yv;
         s1_cv_ff  <= cv;
         s1_fe_ff  <= last_col && last_row;
      end
      if (s1_valid_ff && s1_adv) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

FILE: hdl/rgb2nv12_checker.sv
module rgb2nv12_checker import rgb2nv12_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input result_type rsp_data
);

   logic [1:0] pending_ff, pending_in;
   logic       origin_ff, origin_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + 2'(req_fire) - 2'(rsp_fire);
      origin_in  = origin_ff;
      if (rsp_fire) begin
         origin_in = rsp_data.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         origin_ff  <= 1'b1;
      end else begin
         pending_ff <= pending_in;
         origin_ff  <= origin_in;
      end
   end

   // hold a stalled transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transaction changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("rsp transaction without a matching req transaction");

   assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 && !rsp_ready |-> !req_ready)
      else $error("req accepted with both stages full");

   // first pixel of a frame is valid in both planes and sits at luma offset zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && origin_ff |-> rsp_data.luma_valid && rsp_data.chroma_valid
                                && rsp_data.luma_offset == '0)
      else $error("frame start not at row zero, column zero");

endmodule

bind rgb_to_nv12_converter rgb2nv12_checker u_rgb2nv12_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench import rgb2nv12_pkg::*; ();

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 1700;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 150;
   localparam int MAX_W_EFF    = DEF_MAX_WIDTH & ~1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic                   is_write;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_value;
      pixel_type              pix;
      logic                   typed;
      result_type             want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   rgb2nv12_req_if req_if ();
   rgb2nv12_rsp_if rsp_if ();

   rgb_to_nv12_converter u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   int unsigned cfg_width  = 32'(FRAME_WIDTH_RST);
   int unsigned cfg_height = 32'(FRAME_HEIGHT_RST);
   int unsigned cfg_stride = 32'(OUT_STRIDE_RST);
   int unsigned pix_col    = 0;
   int unsigned pix_row    = 0;

   result_type pending_results[$];
   int         mismatches    = 0;
   int         cycle_count   = 0;
   int         hold_requests = 0;
   int         holds_served  = 0;
   int         hold_left     = 0;
   int         stall_left    = 0;
   logic       quiet         = 1'b0;
   bit         sender_steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic result_type convert_pixel(pixel_type p);
      result_type  res;
      int unsigned w, h, b, g, r;
      bit          last_col, last_row;
      b = 32'(p.blue);
      g = 32'(p.green);
      r = 32'(p.red);
      w = cfg_width & ~32'd1;
      if (w < 2) w = 2;
      if (w > MAX_W_EFF) w = MAX_W_EFF;
      h = cfg_height;
      if (h < 2) h = 2;
      if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
      last_col = (pix_col + 1) >= w;
      last_row = (pix_row + 1) >= h;
      res = '0;
      res.luma_valid   = pix_row < (h & ~32'd1);
      res.chroma_valid = res.luma_valid && (pix_row % 2 == 0) && (pix_col % 2 == 0);
      if (res.luma_valid) begin
         res.luma        = 8'(((66 * r + 129 * g + 25 * b + 128) >> 8) + 16);
         res.luma_offset = 26'(pix_row * cfg_stride + pix_col);
      end
      if (res.chroma_valid) begin
         res.cb            = 8'((112 * b + 128 + 32768 - 38 * r - 74 * g) >> 8);
         res.cr            = 8'((112 * r + 128 + 32768 - 94 * g - 18 * b) >> 8);
         res.chroma_offset = 26'(((pix_row >> 1) + h) * cfg_stride + pix_col);
      end
      res.frame_end = last_col && last_row;
      if (last_col) begin
         pix_col = 0;
         pix_row = last_row ? 0 : ((pix_row + 1) & 32'hFFF);
      end else begin
         pix_col = (pix_col + 1) & 32'hFFF;
      end
      return res;
   endfunction

   function automatic stim_row_type px_step(int b, int g, int r);
      stim_row_type row;
      row = '0;
      row.pix.blue  = b[7:0];
      row.pix.green = g[7:0];
      row.pix.red   = r[7:0];
      return row;
   endfunction

   function automatic stim_row_type known_step(int b, int g, int r, result_type want);
      stim_row_type row;
      row       = px_step(b, g, r);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic stim_row_type reg_step(logic [CSR_INDEX_W-1:0] idx, int value);
      stim_row_type row;
      row           = '0;
      row.is_write  = 1'b1;
      row.reg_index = idx;
      row.reg_value = value[CSR_DATA_W-1:0];
      return row;
   endfunction

   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      p.blue  = random_channel();
      p.green = random_channel();
      p.red   = random_channel();
      return p;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_reg_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 14'd1;
         2: return '1;
         3: return 14'h1FFF;
         4: return 14'd4096;
         5: return 14'($urandom_range(0, 16383));
         default: return 14'($urandom_range(2, 24));
      endcase
   endfunction

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width  = 32'(value[FW_W-1:0]);
         CSR_FRAME_HEIGHT: cfg_height = 32'(value[FH_W-1:0]);
         CSR_OUT_STRIDE:   cfg_stride = 32'(value);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_pixel(pixel_type p, bit typed, result_type want);
      result_type predicted;
      if (!quiet && !sender_steady && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= p;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = convert_pixel(p);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic check_field(string name, longint unsigned exp_val, longint unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transaction on rsp channel");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("luma", want.luma, rsp_if.data.luma);
            check_field("luma_valid", want.luma_valid, rsp_if.data.luma_valid);
            check_field("luma_offset", want.luma_offset, rsp_if.data.luma_offset);
            check_field("chroma_valid", want.chroma_valid, rsp_if.data.chroma_valid);
            check_field("cb", want.cb, rsp_if.data.cb);
            check_field("cr", want.cr, rsp_if.data.cr);
            check_field("chroma_offset", want.chroma_offset, rsp_if.data.chroma_offset);
            check_field("frame_end", want.frame_end, rsp_if.data.frame_end);
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = LONG_HOLD - 1;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type           directed_steps[$];
      logic [CSR_INDEX_W-1:0] idx;
      int                     random_items;
      int                     phase;
      int                     burst;

      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_FRAME_WIDTH;
      csr_wdata    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_steps = '{
         known_step(0, 0, 0, '{8'd16, 1'b1, 26'd0, 1'b1, 8'd128, 8'd128, 26'd307200, 1'b0}),
         known_step(255, 255, 255, '{8'd235, 1'b1, 26'd1, 1'b0, 8'd0, 8'd0, 26'd0, 1'b0}),
         px_step(0, 0, 255),
         px_step(0, 255, 0),
         px_step(255, 0, 0),
         reg_step(CSR_FRAME_WIDTH, 0),
         reg_step(CSR_FRAME_HEIGHT, 1),
         reg_step(CSR_OUT_STRIDE, 0),
         px_step(17, 200, 93),
         px_step(255, 0, 255),
         known_step(0, 0, 0, '{8'd16, 1'b1, 26'd1, 1'b0, 8'd0, 8'd0, 26'd0, 1'b1}),
         reg_step(CSR_FRAME_WIDTH, 8191),
         reg_step(CSR_FRAME_HEIGHT, 8191),
         reg_step(CSR_OUT_STRIDE, 16383),
         known_step(0, 0, 0, '{8'd16, 1'b1, 26'd0, 1'b1, 8'd128, 8'd128, 26'd67104768, 1'b0}),
         px_step(255, 255, 255),
         reg_step(CSR_FRAME_WIDTH, 3),
         reg_step(CSR_FRAME_HEIGHT, 3),
         reg_step(CSR_OUT_STRIDE, 2),
         px_step(0, 255, 255),
         px_step(255, 255, 0),
         px_step(128, 64, 32),
         known_step(90, 90, 90, '{8'd0, 1'b0, 26'd0, 1'b0, 8'd0, 8'd0, 26'd0, 1'b0}),
         known_step(255, 0, 0, '{8'd0, 1'b0, 26'd0, 1'b0, 8'd0, 8'd0, 26'd0, 1'b1}),
         reg_step(CSR_UNUSED, 16383),
         px_step(255, 128, 1)
      };

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_write) begin
            write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
         end else begin
            send_pixel(directed_steps[i].pix, directed_steps[i].typed, directed_steps[i].want);
         end
      end

      random_items = 0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= RANDOM_ITEMS - 200) quiet <= 1'b1;
         if (phase == 1) begin
            // tall, narrow frame: pushes the chroma offset past its wrap
            write_reg(CSR_FRAME_WIDTH, 14'd2);
            write_reg(CSR_FRAME_HEIGHT, 14'h1FFF);
            write_reg(CSR_OUT_STRIDE, 14'h3FFF);
         end else begin
            repeat ($urandom_range(0, 3)) begin
               idx = CSR_INDEX_W'($urandom_range(0, CSR_UNUSED));
               write_reg(idx, pick_reg_value());
            end
         end
         if (phase == 5) drain_results();
         sender_steady = (phase == 3);
         if (phase == 3) hold_requests <= hold_requests + 1;
         burst = (phase == 3) ? 48 : $urandom_range(8, 100);
         repeat (burst) begin
            send_pixel(random_pixel(), 1'b0, '0);
            random_items++;
         end
         sender_steady = 1'b0;
         phase++;
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
